>>> rtl/vpts_pkg.sv
// ----------------------------------------------------------------------------
// vpts_pkg
// shared types, constants and helpers for the vertex projection unit
// ----------------------------------------------------------------------------
package vpts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_W         = 66;
    localparam int NDC_W         = 47;
    localparam int COEF_W        = 32;
    localparam int SIZE_W        = 14;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 128;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VP_WIDTH  = 2'd0,
        REG_VP_HEIGHT = 2'd1,
        REG_RSVD2     = 2'd2,
        REG_RSVD3     = 2'd3
    } cfg_reg_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        begin
            if (v > 65'sd2147483647) begin
                r = 32'sh7fffffff;
            end else if (v < -65'sd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/vertex_project_to_screen_unit.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen_unit
// mvp transform, perspective divide and viewport mapping in fixed point
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                        | tuser
// s_      | in  | coef_index, coef_value, in_x, in_y, in_z  | opcode
// m_      | out | screen_x, screen_y, ndc_depth, clip_w     | w_is_zero
// cfg_    | in  | cfg_index selects register, cfg_data value | -
//
// one item per cycle while the output is not stalled; project items pass
// through the one-bit-per-stage divider pipeline (three lanes) to the output
// synchronous active-low reset clears valid bits and matrix, sets viewport size to 1920 x 1080
// a load item only writes its coefficient and yields no output transfer
// output stall freezes the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module vertex_project_to_screen_unit #(
    parameter int FRAC_BITS = vpts_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coef_index, coef_value, in_x, in_y, in_z, zero pad
    input  logic [vpts_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // screen_x, screen_y, ndc_depth, clip_w
    output logic [vpts_pkg::OUT_DATA_W-1:0]     m_tdata,
    // w_is_zero
    output logic                                m_tuser,
    input  logic                                cfg_wen,
    input  logic [vpts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpts_pkg::SIZE_W-1:0]         cfg_data
);

    localparam int SW = vpts_pkg::SUM_W;
    localparam int CW = SW - FRAC_BITS;
    localparam int QS = vpts_pkg::NDC_W;

    logic        en;
    logic        acc;
    logic [3:0]  in_idx;
    logic signed [31:0] in_val;
    logic signed [31:0] vtx [0:2];

    logic signed [31:0] coef_reg [0:15];
    logic [vpts_pkg::SIZE_W-1:0] vpw_reg, vph_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign in_idx   = s_tdata[3:0];
    assign in_val   = s_tdata[35:4];
    assign vtx[0]   = s_tdata[67:36];
    assign vtx[1]   = s_tdata[99:68];
    assign vtx[2]   = s_tdata[131:100];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpw_reg <= vpts_pkg::WIDTH_RST;
            vph_reg <= vpts_pkg::HEIGHT_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                vpts_pkg::REG_VP_WIDTH:  vpw_reg <= cfg_data;
                vpts_pkg::REG_VP_HEIGHT: vph_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) coef_reg[i] <= '0;
        end else if (acc && s_tuser == vpts_pkg::OP_LOAD) begin
            coef_reg[in_idx] <= in_val;
        end
    end

    // stage 1: products
    logic              v1_reg;
    logic signed [63:0] p1_reg [0:3][0:2];
    logic signed [31:0] t1_reg [0:3];
    // stage 2: partial sums
    logic              v2_reg;
    logic signed [SW-1:0] a2_reg [0:3];
    logic signed [SW-1:0] b2_reg [0:3];
    // stage 3: rounded clip coordinates
    logic              v3_reg;
    logic signed [CW-1:0] c3_reg [0:3];
    // stage 4: magnitudes
    logic              v4_reg;
    logic [CW-1:0]     uc4_reg [0:2];
    logic [2:0]        ng4_reg;
    logic [CW-1:0]     uw4_reg;
    logic              wz4_reg;
    logic signed [31:0] cw4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= acc && s_tuser == vpts_pkg::OP_PROJECT;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 3; k++) begin
                    p1_reg[r][k] <= coef_reg[4*k+r] * vtx[k];
                end
                t1_reg[r] <= coef_reg[12+r];
                a2_reg[r] <= SW'(p1_reg[r][0]) + SW'(p1_reg[r][1]);
                b2_reg[r] <= SW'(p1_reg[r][2])
                           + (SW'(t1_reg[r]) <<< FRAC_BITS)
                           + (SW'(1) << (FRAC_BITS - 1));
                c3_reg[r] <= CW'((a2_reg[r] + b2_reg[r]) >>> FRAC_BITS);
            end
            for (int r = 0; r < 3; r++) begin
                uc4_reg[r] <= c3_reg[r][CW-1] ? CW'(-c3_reg[r]) : CW'(c3_reg[r]);
                ng4_reg[r] <= c3_reg[r][CW-1] ^ c3_reg[3][CW-1];
            end
            wz4_reg <= c3_reg[3] == '0;
            uw4_reg <= (c3_reg[3] == '0) ? CW'(1)
                     : (c3_reg[3][CW-1] ? CW'(-c3_reg[3]) : CW'(c3_reg[3]));
            cw4_reg <= vpts_pkg::sat32(65'(c3_reg[3]));
        end
    end

    // divider pipeline, one quotient bit per stage
    logic              dv_reg  [0:QS];
    logic [CW:0]       dr_reg  [0:QS-1][0:2];
    logic [QS-1:0]     dt_reg  [0:QS-1][0:2];
    logic [QS-1:0]     dq_reg  [0:QS][0:2];
    logic [2:0]        dov_reg [0:QS];
    logic [2:0]        dng_reg [0:QS];
    logic [CW-1:0]     dw_reg  [0:QS];
    logic              dz_reg  [0:QS];
    logic signed [31:0] dc_reg [0:QS];

    logic [SW-1:0] num4 [0:2];
    logic [CW:0]   rs   [0:QS-1][0:2];
    logic          ge   [0:QS-1][0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            num4[j] = SW'(uc4_reg[j]) << FRAC_BITS;
        end
        for (int i = 0; i < QS; i++) begin
            for (int j = 0; j < 3; j++) begin
                rs[i][j] = {dr_reg[i][j][CW-1:0], dt_reg[i][j][QS-1]};
                ge[i][j] = rs[i][j] >= {1'b0, dw_reg[i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QS; i++) dv_reg[i] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v4_reg;
            for (int i = 0; i < QS; i++) dv_reg[i+1] <= dv_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                dr_reg[0][j]  <= (CW+1)'(num4[j][SW-1:QS]);
                dt_reg[0][j]  <= num4[j][QS-1:0];
                dq_reg[0][j]  <= '0;
                dov_reg[0][j] <= (CW+1)'(num4[j][SW-1:QS]) >= {1'b0, uw4_reg};
            end
            dng_reg[0] <= ng4_reg;
            dw_reg[0]  <= uw4_reg;
            dz_reg[0]  <= wz4_reg;
            dc_reg[0]  <= cw4_reg;
            for (int i = 0; i < QS - 1; i++) begin
                for (int j = 0; j < 3; j++) begin
                    dr_reg[i+1][j] <= ge[i][j] ? rs[i][j] - {1'b0, dw_reg[i]} : rs[i][j];
                    dt_reg[i+1][j] <= dt_reg[i][j] << 1;
                end
            end
            for (int i = 0; i < QS; i++) begin
                for (int j = 0; j < 3; j++) begin
                    dq_reg[i+1][j] <= {dq_reg[i][j][QS-2:0], ge[i][j]};
                end
                dov_reg[i+1] <= dov_reg[i];
                dng_reg[i+1] <= dng_reg[i];
                dw_reg[i+1]  <= dw_reg[i];
                dz_reg[i+1]  <= dz_reg[i];
                dc_reg[i+1]  <= dc_reg[i];
            end
        end
    end

    // signed quotient plus one, depth saturation
    logic              v5_reg;
    logic signed [QS+2:0] nx5_reg, ny5_reg;
    logic signed [31:0] nz5_reg, cw5_reg;
    logic              wz5_reg;
    logic signed [QS+1:0] qs [0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qs[j] = dov_reg[QS][j] ? ((QS+2)'(1) << QS) : (QS+2)'(dq_reg[QS][j]);
            if (dng_reg[QS][j]) qs[j] = -qs[j];
        end
    end

    // viewport products
    logic              v6_reg;
    logic signed [QS+17:0] sx6_reg, sy6_reg;
    logic signed [31:0] nz6_reg, cw6_reg;
    logic              wz6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else if (en) begin
            v5_reg   <= dv_reg[QS];
            v6_reg   <= v5_reg;
            m_tvalid <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx5_reg <= (QS+3)'(qs[0]) + ((QS+3)'(1) <<< FRAC_BITS);
            ny5_reg <= (QS+3)'(qs[1]) + ((QS+3)'(1) <<< FRAC_BITS);
            nz5_reg <= vpts_pkg::sat32(65'(qs[2]));
            cw5_reg <= dc_reg[QS];
            wz5_reg <= dz_reg[QS];
            sx6_reg <= nx5_reg * $signed({1'b0, vpw_reg});
            sy6_reg <= ny5_reg * $signed({1'b0, vph_reg});
            nz6_reg <= nz5_reg;
            cw6_reg <= cw5_reg;
            wz6_reg <= wz5_reg;
            if (wz6_reg) begin
                m_tdata <= '0;
            end else begin
                m_tdata <= {cw6_reg, nz6_reg,
                            vpts_pkg::sat32(65'(sy6_reg >>> 1)),
                            vpts_pkg::sat32(65'(sx6_reg >>> 1))};
            end
            m_tuser <= wz6_reg;
        end
    end

endmodule
